### rtl/assert_macros.svh
// Assertion macros shared by the form field extractor RTL.
// Every macro expects clk_i and the active-low reset rst_ni in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ffe_pkg.sv
// Shared types and constants for the form field extractor with percent decoding.
// No dependencies; every RTL module imports this package.
`timescale 1ns / 1ps

package ffe_pkg;

  // Default sizes handed to the top level parameters.
  localparam int KEY_BYTES_DEF           = 8;
  localparam int TRUTHY_WINDOW_BYTES_DEF = 7;

  // A body byte causes at most three result transactions.
  localparam int RES_SLOTS = 3;

  // Field widths of the configuration registers and payload.
  localparam int NAME_W  = 64;
  localparam int FLEN_W  = 4;
  localparam int MAXV_W  = 8;
  localparam int BYTE_W  = 8;
  localparam int CADDR_W = 2;

  // Characters with a meaning in the body.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PLUS    = "+";
  localparam logic [7:0] CH_PCT     = "%";
  localparam logic [7:0] CH_EQ      = "=";
  localparam logic [7:0] CH_AMP     = "&";
  localparam logic [7:0] CH_SPACE   = " ";
  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_NINE    = "9";
  localparam logic [7:0] CH_UPPER_A = "A";
  localparam logic [7:0] CH_UPPER_F = "F";
  localparam logic [7:0] CH_UPPER_Z = "Z";
  localparam logic [7:0] CH_LOWER_A = "a";
  localparam logic [7:0] CH_LOWER_F = "f";

  localparam logic [7:0] HEX_ALPHA_OFFSET = 8'd10;
  localparam logic [7:0] CASE_OFFSET      = 8'd32;

  // Words that make a value truthy, first character in the top byte.
  localparam logic [7:0]  WORD_ONE  = "1";
  localparam logic [31:0] WORD_TRUE = "true";
  localparam logic [23:0] WORD_YES  = "yes";

  // Configuration register indexes.
  typedef enum logic [CADDR_W-1:0] {
    CFG_FIELD_NAME      = 2'd0,
    CFG_FIELD_LENGTH    = 2'd1,
    CFG_MAX_VALUE_BYTES = 2'd2
  } cfg_reg_e;

  // Parser phase within one body.
  typedef enum logic [1:0] {
    PH_KEY   = 2'd0,
    PH_SKIP  = 2'd1,
    PH_VALUE = 2'd2,
    PH_IDLE  = 2'd3
  } phase_e;

  // Progress through a percent escape.
  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HEX1 = 2'd2
  } esc_e;

  // One result transaction.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              done;
    logic              found;
    logic              truthy;
  } res_t;

endpackage

### rtl/ffe_parser.sv
// Body parser: per-byte key matching, value decoding, truthy window and limit.
// Depends on ffe_pkg and assert_macros.svh; produces up to three results a byte.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffe_parser import ffe_pkg::*; #(
  parameter int KEY_BYTES           = KEY_BYTES_DEF,
  parameter int TRUTHY_WINDOW_BYTES = TRUTHY_WINDOW_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic [NAME_W-1:0] field_name_i,
  input  logic [FLEN_W-1:0] field_length_i,
  input  logic [MAXV_W-1:0] max_value_bytes_i,
  output res_t              res_o [RES_SLOTS],
  output logic [1:0]        res_n_o
);

  localparam int KPW = $clog2(KEY_BYTES + 1);
  localparam int KIW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int TW  = TRUTHY_WINDOW_BYTES;
  localparam int TCW = $clog2(TW + 1);

  function automatic logic hex_ok(input logic [7:0] c);
    hex_ok = (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UPPER_A && c <= CH_UPPER_F) ||
             (c >= CH_LOWER_A && c <= CH_LOWER_F);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      hex_val = 4'(c - CH_ZERO);
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      hex_val = 4'(c - CH_UPPER_A + HEX_ALPHA_OFFSET);
    end else begin
      hex_val = 4'(c - CH_LOWER_A + HEX_ALPHA_OFFSET);
    end
  endfunction

  function automatic logic [7:0] lower_case(input logic [7:0] c);
    lower_case = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
  endfunction

  // Body state.
  phase_e          phase_q, phase_d;
  logic [KPW-1:0]  kp_q, kp_d;
  logic            match_q, match_d;
  esc_e            esc_q, esc_d;
  logic [7:0]      first_q, first_d;
  logic [MAXV_W-1:0] emitted_q, emitted_d;
  logic [7:0]      win_q [TW];
  logic [7:0]      win_d [TW];
  logic [TCW-1:0]  tcnt_q, tcnt_d;

  // Decoded bytes of this step, in order, and the final result request.
  logic [7:0]      dec_b [RES_SLOTS];
  logic [1:0]      dec_n;
  logic            fin, fnd, clr, enter_value;
  logic [7:0]      name_b [KEY_BYTES];

  logic            term, amp;
  logic            p_emit, p_esc;
  logic [7:0]      p_byte;

  logic [TCW:0]    tsum;
  logic [TCW-1:0]  tcnt_upd;
  logic [MAXV_W-1:0] room;
  logic [1:0]      emit_k;
  logic [7:0]      pad [4];
  logic            truthy;

  // Key characters as bytes, first character at index zero.
  always_comb begin
    for (int i = 0; i < KEY_BYTES; i++) begin
      name_b[i] = field_name_i[8*i +: 8];
    end
  end

  assign term = (byte_i == CH_NUL);
  assign amp  = (byte_i == CH_AMP);

  // How a plain value byte decodes: plus becomes a space, percent opens an escape.
  assign p_emit = (byte_i != CH_PCT);
  assign p_esc  = (byte_i == CH_PCT);
  assign p_byte = (byte_i == CH_PLUS) ? CH_SPACE : byte_i;

  // Phase decisions and the list of decoded bytes.
  always_comb begin
    phase_d     = phase_q;
    kp_d        = kp_q;
    match_d     = match_q;
    esc_d       = esc_q;
    first_d     = first_q;
    fin         = 1'b0;
    fnd         = 1'b0;
    clr         = 1'b0;
    enter_value = 1'b0;
    dec_n       = 2'd0;
    for (int j = 0; j < RES_SLOTS; j++) begin
      dec_b[j] = CH_NUL;
    end

    unique case (phase_q)
      PH_KEY: begin
        if (term || amp) begin
          fin = 1'b1;
          if (term) begin
            clr = 1'b1;
          end else begin
            phase_d = PH_IDLE;
          end
        end else if (byte_i == CH_EQ) begin
          if (match_q && (FLEN_W'(kp_q) == field_length_i)) begin
            phase_d     = PH_VALUE;
            esc_d       = ESC_NONE;
            enter_value = 1'b1;
          end else begin
            phase_d = PH_SKIP;
          end
        end else if (match_q && (FLEN_W'(kp_q) < field_length_i) &&
                     (kp_q < KPW'(KEY_BYTES)) && (name_b[kp_q[KIW-1:0]] == byte_i)) begin
          kp_d = kp_q + 1'b1;
        end else begin
          match_d = 1'b0;
        end
      end
      PH_SKIP: begin
        if (term) begin
          fin = 1'b1;
          clr = 1'b1;
        end else if (amp) begin
          phase_d = PH_KEY;
          kp_d    = '0;
          match_d = 1'b1;
        end
      end
      PH_VALUE: begin
        if (term || amp) begin
          // A cut-off escape is flushed literally before the final result.
          dec_b[0] = CH_PCT;
          dec_b[1] = first_q;
          dec_n    = (esc_q == ESC_NONE) ? 2'd0 : ((esc_q == ESC_PCT) ? 2'd1 : 2'd2);
          esc_d    = ESC_NONE;
          fin      = 1'b1;
          fnd      = 1'b1;
          if (term) begin
            clr = 1'b1;
          end else begin
            phase_d = PH_IDLE;
          end
        end else begin
          unique case (esc_q)
            ESC_PCT: begin
              if (hex_ok(byte_i)) begin
                first_d = byte_i;
                esc_d   = ESC_HEX1;
              end else begin
                dec_b[0] = CH_PCT;
                dec_b[1] = p_byte;
                dec_n    = p_emit ? 2'd2 : 2'd1;
                esc_d    = p_esc ? ESC_PCT : ESC_NONE;
              end
            end
            ESC_HEX1: begin
              if (hex_ok(byte_i)) begin
                dec_b[0] = {hex_val(first_q), hex_val(byte_i)};
                dec_n    = 2'd1;
                esc_d    = ESC_NONE;
              end else begin
                dec_b[0] = CH_PCT;
                dec_b[1] = first_q;
                dec_b[2] = p_byte;
                dec_n    = p_emit ? 2'd3 : 2'd2;
                esc_d    = p_esc ? ESC_PCT : ESC_NONE;
              end
            end
            default: begin
              dec_b[0] = p_byte;
              dec_n    = p_emit ? 2'd1 : 2'd0;
              esc_d    = p_esc ? ESC_PCT : ESC_NONE;
            end
          endcase
        end
      end
      PH_IDLE: begin
        if (term) begin
          clr = 1'b1;
        end
      end
      default: begin
        clr = 1'b1;
      end
    endcase

    // The terminator starts a fresh body.
    if (clr) begin
      phase_d = PH_KEY;
      kp_d    = '0;
      match_d = 1'b1;
      esc_d   = ESC_NONE;
    end
  end

  // Truthy window: the decoded bytes land at the current fill position onwards.
  always_comb begin
    for (int i = 0; i < TW; i++) begin
      win_d[i] = win_q[i];
      for (int j = 0; j < RES_SLOTS; j++) begin
        if ((j < int'(dec_n)) && (int'(tcnt_q) + j == i)) begin
          win_d[i] = dec_b[j];
        end
      end
    end
    tsum     = {1'b0, tcnt_q} + (TCW+1)'(dec_n);
    tcnt_upd = (tsum > (TCW+1)'(TW)) ? TCW'(TW) : tsum[TCW-1:0];
    for (int k = 0; k < 4; k++) begin
      pad[k] = CH_NUL;
      if (k < TW) begin
        pad[k] = win_d[k];
      end
    end
    truthy = ((int'(tcnt_upd) == 1) && (lower_case(pad[0]) == WORD_ONE)) ||
             ((int'(tcnt_upd) == 4) && (lower_case(pad[0]) == WORD_TRUE[31:24]) &&
              (lower_case(pad[1]) == WORD_TRUE[23:16]) &&
              (lower_case(pad[2]) == WORD_TRUE[15:8]) &&
              (lower_case(pad[3]) == WORD_TRUE[7:0])) ||
             ((int'(tcnt_upd) == 3) && (lower_case(pad[0]) == WORD_YES[23:16]) &&
              (lower_case(pad[1]) == WORD_YES[15:8]) &&
              (lower_case(pad[2]) == WORD_YES[7:0]));
  end

  // Output limit: only the bytes that still fit under max_value_bytes are emitted.
  always_comb begin
    room   = (emitted_q < max_value_bytes_i) ? max_value_bytes_i - emitted_q : '0;
    emit_k = (room < MAXV_W'(dec_n)) ? room[1:0] : dec_n;
    if (clr || enter_value) begin
      emitted_d = '0;
      tcnt_d    = '0;
    end else begin
      emitted_d = emitted_q + MAXV_W'(emit_k);
      tcnt_d    = tcnt_upd;
    end
  end

  // Pack the emitted bytes and then the final result into the result slots.
  always_comb begin
    for (int j = 0; j < RES_SLOTS; j++) begin
      res_o[j] = '{data: dec_b[j], done: 1'b0, found: 1'b0, truthy: 1'b0};
      if ((j >= int'(emit_k)) && fin) begin
        res_o[j] = '{data: CH_NUL, done: 1'b1, found: fnd, truthy: fnd && truthy};
      end
    end
    res_n_o = emit_k + {1'b0, fin};
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_KEY;
      kp_q      <= '0;
      match_q   <= 1'b1;
      esc_q     <= ESC_NONE;
      emitted_q <= '0;
      tcnt_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      kp_q      <= kp_d;
      match_q   <= match_d;
      esc_q     <= esc_d;
      emitted_q <= emitted_d;
      tcnt_q    <= tcnt_d;
    end
  end

  // Escape digit and window contents are only read under the control state.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      first_q <= first_d;
      win_q   <= win_d;
    end
  end

  // After the decision nothing is produced until the terminator.
  `FFE_ASSERT_IMPL(idle_is_silent, step_i && (phase_q == PH_IDLE), res_n_o == 2'd0, "result after decision")
  // The final result is last and appears only on a byte that ends a segment.
  `FFE_ASSERT_IMPL(final_only_on_end, step_i && fin, term || amp, "final result without end of segment")

endmodule

### rtl/ffe_res_buf.sv
// Result buffer: holds the up to three result transactions of one body byte.
// Depends on ffe_pkg and assert_macros.svh; the head entry drives the output.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffe_res_buf import ffe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  res_t       res_i [RES_SLOTS],
  input  logic [1:0] res_n_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output res_t       head_o,
  output logic       load_ok_o
);

  res_t       ent_q [RES_SLOTS];
  logic [1:0] cnt_q;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign head_o      = ent_q[0];
  assign pop         = out_valid_o && out_ready_i;

  // A new byte may load once the buffer is empty or its last entry leaves now.
  assign load_ok_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  // Fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= res_n_i;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Entries shift towards the head as transactions leave.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= res_i;
    end else if (pop) begin
      for (int j = 0; j < RES_SLOTS - 1; j++) begin
        ent_q[j] <= ent_q[j+1];
      end
    end
  end

  `FFE_ASSERT_NEXT(load_sets_count, load_i, cnt_q == $past(res_n_i), "fill count differs from load")
  `FFE_ASSERT_NEXT(pop_drops_one, pop && !load_i, cnt_q == $past(cnt_q) - 2'd1, "pop miscounted")

endmodule

### rtl/form_field_extract_url_decode.sv
// Form field extractor: one body byte per cycle is accepted while the result buffer can
// take it; a byte that causes two or three result transactions, or an output that is not
// ready, holds the input while the three-entry result buffer drains. Results appear in the
// cycle after their byte. The key match, the percent decoding, the output limit and the
// truthy check all sit between the input handshake and that result buffer, so the rate is
// set by the buffer's single output port. Depends on ffe_pkg, ffe_parser and ffe_res_buf.
`timescale 1ns / 1ps

module form_field_extract_url_decode import ffe_pkg::*; #(
  parameter int KEY_BYTES           = KEY_BYTES_DEF,
  parameter int TRUTHY_WINDOW_BYTES = TRUTHY_WINDOW_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CADDR_W-1:0] cfg_addr_i,
  input  logic [NAME_W-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [BYTE_W-1:0]  body_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [BYTE_W-1:0]  out_byte_o,
  output logic               done_res_o,
  output logic               found_o,
  output logic               truthy_o
);

  logic [NAME_W-1:0] field_name_q;
  logic [FLEN_W-1:0] field_length_q;
  logic [MAXV_W-1:0] max_value_bytes_q;

  logic       step;
  res_t       res [RES_SLOTS];
  logic [1:0] res_n;
  res_t       head;
  logic       load_ok;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_name_q      <= '0;
      field_length_q    <= '0;
      max_value_bytes_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_FIELD_NAME:      field_name_q      <= cfg_wdata_i;
        CFG_FIELD_LENGTH:    field_length_q    <= cfg_wdata_i[FLEN_W-1:0];
        CFG_MAX_VALUE_BYTES: max_value_bytes_q <= cfg_wdata_i[MAXV_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = load_ok;
  assign step       = in_valid_i && in_ready_o;

  ffe_parser #(
    .KEY_BYTES          (KEY_BYTES),
    .TRUTHY_WINDOW_BYTES(TRUTHY_WINDOW_BYTES)
  ) u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .byte_i           (body_byte_i),
    .field_name_i     (field_name_q),
    .field_length_i   (field_length_q),
    .max_value_bytes_i(max_value_bytes_q),
    .res_o            (res),
    .res_n_o          (res_n)
  );

  ffe_res_buf u_res_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step),
    .res_i      (res),
    .res_n_i    (res_n),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .head_o     (head),
    .load_ok_o  (load_ok)
  );

  // Result transaction fields.
  assign out_byte_o = head.data;
  assign done_res_o = head.done;
  assign found_o    = head.found;
  assign truthy_o   = head.truthy;

endmodule
